// File: sv/shpa_pkg.sv
// Shared types, constants and controller/datapath interface structs for the spectrum histogram.
package shpa_pkg;

    localparam int DEF_MAX_CHANNELS = 4096;
    localparam int DEF_COUNT_WIDTH  = 32;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int NCH_W       = 13;
    localparam int PEAK_W      = 16;
    localparam int CH_W        = 17;
    localparam int IDX_W       = 17;
    localparam int SUM_W       = 49;
    localparam int WSUM_W      = 44;
    localparam int AREA_W      = 50;
    localparam int OUT_CNT_W   = 32;

    localparam logic [NCH_W-1:0] NUM_CHANNELS_RST = 13'd4096;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_EVENT  = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUM_CHANNELS = 2'd0,
        REG_PEAK_LOW     = 2'd1,
        REG_PEAK_HIGH    = 2'd2
    } t_reg_index;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EV_RD,
        ST_EV_WR,
        ST_RD,
        ST_RD_OUT,
        ST_CLR,
        ST_CLR_OUT,
        ST_FIN_SETUP,
        ST_FIN_WALK,
        ST_FIN_DRAIN,
        ST_FIN_MUL,
        ST_FIN_OUT
    } t_state;

    typedef struct packed {
        logic  load;
        logic  clr_total;
        logic  clr_wr;
        logic  ev_rd;
        logic  ev_wr;
        logic  rd_issue;
        logic  fin_setup;
        logic  walk_rd;
        logic  mul;
        logic  out_load;
        t_kind out_kind;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_empty;
        logic walk_last;
        logic out_free;
    } t_status;

endpackage

// File: sv/shpa_ctrl.sv
// Controller state machine: sequences clear sweeps, event updates, bin reads and the peak walk.
module shpa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_action,
    input  logic                 i_filters_pass,
    input  shpa_pkg::t_status    i_status,
    output logic                 o_in_ready,
    output shpa_pkg::t_cmd       o_cmd
);

    shpa_pkg::t_state r_state;
    shpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shpa_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_kind = shpa_pkg::KIND_CLEAR;
        case (r_state)
            shpa_pkg::ST_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = shpa_pkg::ST_IDLE;
                end
            end
            shpa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (shpa_pkg::t_action'(i_action))
                        shpa_pkg::ACT_CLEAR: begin
                            o_cmd.clr_total = 1'b1;
                            n_state = shpa_pkg::ST_CLR;
                        end
                        shpa_pkg::ACT_EVENT: begin
                            // drop rejected events here
                            if (i_filters_pass) begin
                                n_state = shpa_pkg::ST_EV_RD;
                            end
                        end
                        shpa_pkg::ACT_FINISH: n_state = shpa_pkg::ST_FIN_SETUP;
                        shpa_pkg::ACT_READ:   n_state = shpa_pkg::ST_RD;
                        default:              n_state = shpa_pkg::ST_IDLE;
                    endcase
                end
            end
            shpa_pkg::ST_EV_RD: begin
                o_cmd.ev_rd = 1'b1;
                n_state = shpa_pkg::ST_EV_WR;
            end
            shpa_pkg::ST_EV_WR: begin
                o_cmd.ev_wr = 1'b1;
                n_state = shpa_pkg::ST_IDLE;
            end
            shpa_pkg::ST_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = shpa_pkg::ST_RD_OUT;
            end
            shpa_pkg::ST_RD_OUT: begin
                o_cmd.out_kind = shpa_pkg::KIND_READ;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = shpa_pkg::ST_IDLE;
                end
            end
            shpa_pkg::ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = shpa_pkg::ST_CLR_OUT;
                end
            end
            shpa_pkg::ST_CLR_OUT: begin
                o_cmd.out_kind = shpa_pkg::KIND_CLEAR;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = shpa_pkg::ST_IDLE;
                end
            end
            shpa_pkg::ST_FIN_SETUP: begin
                o_cmd.fin_setup = 1'b1;
                n_state = i_status.walk_empty ? shpa_pkg::ST_FIN_MUL : shpa_pkg::ST_FIN_WALK;
            end
            shpa_pkg::ST_FIN_WALK: begin
                o_cmd.walk_rd = 1'b1;
                if (i_status.walk_last) begin
                    n_state = shpa_pkg::ST_FIN_DRAIN;
                end
            end
            shpa_pkg::ST_FIN_DRAIN: begin
                // last bin of the window accumulates on this edge
                n_state = shpa_pkg::ST_FIN_MUL;
            end
            shpa_pkg::ST_FIN_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = shpa_pkg::ST_FIN_OUT;
            end
            shpa_pkg::ST_FIN_OUT: begin
                o_cmd.out_kind = shpa_pkg::KIND_FINISH;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = shpa_pkg::ST_IDLE;
                end
            end
            default: n_state = shpa_pkg::ST_INIT;
        endcase
    end

endmodule

// File: sv/shpa_dp.sv
// Datapath: bin memory, event total, configuration registers, peak walk and result register.
module shpa_dp #(
    parameter int MAX_CHANNELS = shpa_pkg::DEF_MAX_CHANNELS,
    parameter int COUNT_WIDTH  = shpa_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  shpa_pkg::t_cmd                      i_cmd,
    output shpa_pkg::t_status                   o_status,
    input  logic                                i_cfg_valid,
    input  logic [shpa_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [shpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [shpa_pkg::CH_W-1:0]           i_channel,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [1:0]                          o_kind,
    output logic [shpa_pkg::OUT_CNT_W-1:0]      o_bin_count,
    output logic [shpa_pkg::OUT_CNT_W-1:0]      o_event_total,
    output logic [shpa_pkg::WSUM_W-1:0]         o_window_sum,
    output logic [shpa_pkg::AREA_W-1:0]         o_background_x2,
    output logic [shpa_pkg::AREA_W-1:0]         o_net_area_x2
);

    localparam int AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EDGE_W = COUNT_WIDTH + 1;
    localparam int PROD_W = shpa_pkg::IDX_W + EDGE_W;
    localparam int IW     = shpa_pkg::IDX_W;

    // configuration
    logic [shpa_pkg::NCH_W-1:0]  r_num_channels;
    logic [shpa_pkg::PEAK_W-1:0] r_peak_low;
    logic [shpa_pkg::PEAK_W-1:0] r_peak_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= shpa_pkg::NUM_CHANNELS_RST;
            r_peak_low     <= '0;
            r_peak_high    <= '0;
        end else if (i_cfg_valid) begin
            case (shpa_pkg::t_reg_index'(i_cfg_index))
                shpa_pkg::REG_NUM_CHANNELS: r_num_channels <= i_cfg_data[shpa_pkg::NCH_W-1:0];
                shpa_pkg::REG_PEAK_LOW:     r_peak_low     <= i_cfg_data;
                shpa_pkg::REG_PEAK_HIGH:    r_peak_high    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [IW-1:0]               w_active;
    logic [shpa_pkg::PEAK_W-1:0] w_hi_eff;
    logic [IW-1:0]               w_lo_x;
    logic [IW-1:0]               w_hi_x;
    logic [IW-1:0]               w_end;

    assign w_active = (IW'(r_num_channels) < IW'(MAX_CHANNELS)) ? IW'(r_num_channels)
                                                                : IW'(MAX_CHANNELS);
    assign w_hi_eff = (r_peak_high < r_peak_low) ? r_peak_low : r_peak_high;
    assign w_lo_x   = IW'(r_peak_low);
    assign w_hi_x   = IW'(w_hi_eff);
    assign w_end    = (w_hi_x < w_active) ? w_hi_x : (w_active - IW'(1));

    // latched request channel
    logic [shpa_pkg::CH_W-1:0] r_channel;
    logic                      w_in_range;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_channel <= i_channel;
        end
    end

    assign w_in_range = !r_channel[shpa_pkg::CH_W-1]
                        && (IW'(r_channel[shpa_pkg::CH_W-2:0]) < w_active);

    // bin memory
    logic [COUNT_WIDTH-1:0] r_mem [MAX_CHANNELS];
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [COUNT_WIDTH-1:0] w_wdata;
    logic [COUNT_WIDTH-1:0] w_bin_inc;
    logic [AW-1:0]          r_clr_addr;
    logic [AW-1:0]          r_walk_addr;
    logic [AW-1:0]          r_walk_end;

    assign w_bin_inc = (r_rdata == '1) ? r_rdata : r_rdata + COUNT_WIDTH'(1);

    always_comb begin
        w_re    = i_cmd.ev_rd || i_cmd.rd_issue || i_cmd.walk_rd;
        w_raddr = i_cmd.walk_rd ? r_walk_addr : r_channel[AW-1:0];
        w_we    = i_cmd.clr_wr || (i_cmd.ev_wr && w_in_range);
        w_waddr = i_cmd.clr_wr ? r_clr_addr : r_channel[AW-1:0];
        w_wdata = i_cmd.clr_wr ? '0 : w_bin_inc;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= o_status.clr_last ? '0 : r_clr_addr + AW'(1);
        end
    end

    // event total
    logic [COUNT_WIDTH-1:0] r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_total) begin
            r_total <= '0;
        end else if (i_cmd.ev_rd && r_total != '1) begin
            r_total <= r_total + COUNT_WIDTH'(1);
        end
    end

    // peak walk: read one bin a cycle, accumulate it in the cycle after its read
    logic                   r_acc_en;
    logic [AW-1:0]          r_acc_addr;
    logic [shpa_pkg::SUM_W-1:0] r_sum;
    logic [COUNT_WIDTH-1:0] r_edge_lo;
    logic [COUNT_WIDTH-1:0] r_edge_hi;
    logic [IW-1:0]          r_width;
    logic [shpa_pkg::AREA_W-1:0] r_bg;
    logic [PROD_W-1:0]      w_width_ext;
    logic [PROD_W-1:0]      w_edges_ext;
    logic [PROD_W-1:0]      w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.walk_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_setup) begin
            r_walk_addr <= r_peak_low[AW-1:0];
            r_walk_end  <= w_end[AW-1:0];
            r_width     <= w_hi_x - w_lo_x + IW'(1);
        end else if (i_cmd.walk_rd) begin
            r_walk_addr <= r_walk_addr + AW'(1);
        end
        r_acc_addr <= r_walk_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_setup) begin
            r_sum     <= '0;
            r_edge_lo <= '0;
            r_edge_hi <= '0;
        end else if (r_acc_en) begin
            r_sum <= r_sum + shpa_pkg::SUM_W'(r_rdata);
            if (IW'(r_acc_addr) == w_lo_x) begin
                r_edge_lo <= r_rdata;
            end
            if (IW'(r_acc_addr) == w_hi_x) begin
                r_edge_hi <= r_rdata;
            end
        end
    end

    assign w_width_ext = PROD_W'(r_width);
    assign w_edges_ext = PROD_W'(EDGE_W'(r_edge_lo) + EDGE_W'(r_edge_hi));
    assign w_prod      = w_width_ext * w_edges_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_bg <= shpa_pkg::AREA_W'(w_prod);
        end
    end

    // result register
    logic                           r_out_valid;
    shpa_pkg::t_kind                r_kind;
    logic [shpa_pkg::OUT_CNT_W-1:0] r_bin_count;
    logic [shpa_pkg::OUT_CNT_W-1:0] r_event_total;
    logic [shpa_pkg::WSUM_W-1:0]    r_window_sum;
    logic [shpa_pkg::AREA_W-1:0]    r_background_x2;
    logic [shpa_pkg::AREA_W-1:0]    r_net_area_x2;
    logic                           w_is_fin;
    logic                           w_is_rd;

    assign w_is_fin = (i_cmd.out_kind == shpa_pkg::KIND_FINISH);
    assign w_is_rd  = (i_cmd.out_kind == shpa_pkg::KIND_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind          <= i_cmd.out_kind;
            r_bin_count     <= (w_is_rd && w_in_range) ? shpa_pkg::OUT_CNT_W'(r_rdata) : '0;
            r_event_total   <= (w_is_rd || w_is_fin) ? shpa_pkg::OUT_CNT_W'(r_total) : '0;
            r_window_sum    <= w_is_fin ? shpa_pkg::WSUM_W'(r_sum) : '0;
            r_background_x2 <= w_is_fin ? r_bg : '0;
            r_net_area_x2   <= w_is_fin ? ({r_sum, 1'b0} - r_bg) : '0;
        end
    end

    assign o_status.clr_last   = (r_clr_addr == AW'(MAX_CHANNELS - 1));
    assign o_status.walk_empty = (w_lo_x >= w_active);
    assign o_status.walk_last  = (r_walk_addr == r_walk_end);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_bin_count     = r_bin_count;
    assign o_event_total   = r_event_total;
    assign o_window_sum    = r_window_sum;
    assign o_background_x2 = r_background_x2;
    assign o_net_area_x2   = r_net_area_x2;

endmodule

// File: sv/spectrum_histogram_peak_area.sv
// Top level of the spectrum histogram with trapezoid-background peak integral.
//
//  channel  | signals                                           | direction
//  ---------+---------------------------------------------------+----------
//  request  | i_in_valid/o_in_ready, action, channel, filters  | in
//  result   | o_out_valid/i_out_ready, kind .. net_area_x2      | out
//  config   | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data  | in
//
// One request at a time; the bin memory sets the pace. An event is accepted, read
// and written back; a bin read is accepted, issued and then handed to the output; a
// clear zeroes one bin per cycle, then hands off its result; a finish sets up, walks
// the bins in the window, drains, multiplies and hands off. After reset a clearing pass
// over all MAX_CHANNELS bins runs before the first request is taken; configuration
// writes are taken at any time. A stalled result holds in the output register; a new request waits only for it.
module spectrum_histogram_peak_area #(
    parameter int MAX_CHANNELS = shpa_pkg::DEF_MAX_CHANNELS,
    parameter int COUNT_WIDTH  = shpa_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_action,
    input  logic signed [shpa_pkg::CH_W-1:0]      i_channel,
    input  logic                                  i_filters_pass,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_kind,
    output logic [shpa_pkg::OUT_CNT_W-1:0]        o_bin_count,
    output logic [shpa_pkg::OUT_CNT_W-1:0]        o_event_total,
    output logic [shpa_pkg::WSUM_W-1:0]           o_window_sum,
    output logic [shpa_pkg::AREA_W-1:0]           o_background_x2,
    output logic signed [shpa_pkg::AREA_W-1:0]    o_net_area_x2,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [shpa_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [shpa_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    shpa_pkg::t_cmd              w_cmd;
    shpa_pkg::t_status           w_status;
    logic [shpa_pkg::AREA_W-1:0] w_net;

    assign o_cfg_ready = 1'b1;

    shpa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_action       (i_action),
        .i_filters_pass (i_filters_pass),
        .i_status       (w_status),
        .o_in_ready     (o_in_ready),
        .o_cmd          (w_cmd)
    );

    shpa_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_channel       (i_channel),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_bin_count     (o_bin_count),
        .o_event_total   (o_event_total),
        .o_window_sum    (o_window_sum),
        .o_background_x2 (o_background_x2),
        .o_net_area_x2   (w_net)
    );

    assign o_net_area_x2 = $signed(w_net);

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the spectrum histogram with trapezoid-background peak area.
module tb_top;
    import shpa_pkg::*;

    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [1:0]           kind;
        logic [OUT_CNT_W-1:0] bin_count;
        logic [OUT_CNT_W-1:0] event_total;
        logic [WSUM_W-1:0]    window_sum;
        logic [AREA_W-1:0]    background_x2;
        logic [AREA_W-1:0]    net_area_x2;
    } peak_report_t;

    class histogram_scoreboard;
        bit [OUT_CNT_W-1:0] bin_counts [DEF_MAX_CHANNELS];
        bit [OUT_CNT_W-1:0] accepted_total;
        bit [NCH_W-1:0]     num_channels;
        bit [PEAK_W-1:0]    peak_low;
        bit [PEAK_W-1:0]    peak_high;
        peak_report_t       expected_reports [$];
        int                 mismatches;

        function new();
            foreach (bin_counts[i]) bin_counts[i] = '0;
            accepted_total = '0;
            num_channels   = NUM_CHANNELS_RST;
            peak_low       = '0;
            peak_high      = '0;
            mismatches     = 0;
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] %s", $time, msg);
            mismatches++;
        endtask

        function void set_register(t_reg_index idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NUM_CHANNELS: num_channels = data[NCH_W-1:0];
                REG_PEAK_LOW:     peak_low = data;
                REG_PEAK_HIGH:    peak_high = data;
                default: ;
            endcase
        endfunction

        function longint bins_in_use();
            return (num_channels > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : longint'(num_channels);
        endfunction

        // Channels outside the bins in use read as zero.
        function bit [OUT_CNT_W-1:0] count_at(longint ch);
            if (ch < 0 || ch >= bins_in_use()) return '0;
            return bin_counts[ch];
        endfunction

        function void note_request(t_action act, logic signed [CH_W-1:0] ch, logic pass);
            peak_report_t rep;
            longint       ch_val;
            longint       lo;
            longint       hi;
            longint       idx;
            logic [63:0]  sum;
            logic [63:0]  span;
            logic [63:0]  edges;
            logic [63:0]  bg;
            logic [63:0]  net;
            rep = '0;
            ch_val = ch;
            case (act)
                ACT_CLEAR: begin
                    foreach (bin_counts[i]) bin_counts[i] = '0;
                    accepted_total = '0;
                    rep.kind = KIND_CLEAR;
                    expected_reports.push_back(rep);
                end
                ACT_EVENT: begin
                    if (pass) begin
                        if (accepted_total != '1) accepted_total++;
                        if (ch_val >= 0 && ch_val < bins_in_use() && bin_counts[ch_val] != '1)
                            bin_counts[ch_val]++;
                    end
                end
                ACT_FINISH: begin
                    lo = peak_low;
                    hi = (peak_high < peak_low) ? lo : longint'(peak_high);
                    sum = '0;
                    for (idx = lo; idx <= hi && idx < bins_in_use(); idx++)
                        sum += bin_counts[idx];
                    span  = hi - lo + 1;
                    edges = 64'(count_at(lo)) + 64'(count_at(hi));
                    bg    = span * edges;
                    net   = (sum << 1) - bg;
                    rep.kind          = KIND_FINISH;
                    rep.event_total   = accepted_total;
                    rep.window_sum    = sum[WSUM_W-1:0];
                    rep.background_x2 = bg[AREA_W-1:0];
                    rep.net_area_x2   = net[AREA_W-1:0];
                    expected_reports.push_back(rep);
                end
                default: begin
                    rep.kind        = KIND_READ;
                    rep.bin_count   = count_at(ch_val);
                    rep.event_total = accepted_total;
                    expected_reports.push_back(rep);
                end
            endcase
        endfunction

        task check_result(peak_report_t got);
            peak_report_t exp_rep;
            string        diffs;
            if (expected_reports.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind %0d", got.kind));
                return;
            end
            exp_rep = expected_reports.pop_front();
            diffs = "";
            if (got.kind !== exp_rep.kind)
                diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, exp_rep.kind)};
            if (got.bin_count !== exp_rep.bin_count)
                diffs = {diffs, $sformatf(" bin_count %0d/%0d", got.bin_count,
                                          exp_rep.bin_count)};
            if (got.event_total !== exp_rep.event_total)
                diffs = {diffs, $sformatf(" event_total %0d/%0d", got.event_total,
                                          exp_rep.event_total)};
            if (got.window_sum !== exp_rep.window_sum)
                diffs = {diffs, $sformatf(" window_sum %0d/%0d", got.window_sum,
                                          exp_rep.window_sum)};
            if (got.background_x2 !== exp_rep.background_x2)
                diffs = {diffs, $sformatf(" background_x2 %0d/%0d", got.background_x2,
                                          exp_rep.background_x2)};
            if (got.net_area_x2 !== exp_rep.net_area_x2)
                diffs = {diffs, $sformatf(" net_area_x2 %h/%h", got.net_area_x2,
                                          exp_rep.net_area_x2)};
            if (diffs != "")
                flag_mismatch({"result differs (got/expected):", diffs});
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [1:0]                  i_action = ACT_CLEAR;
    logic signed [CH_W-1:0]      i_channel = '0;
    logic                        i_filters_pass = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [1:0]                  o_kind;
    logic [OUT_CNT_W-1:0]        o_bin_count;
    logic [OUT_CNT_W-1:0]        o_event_total;
    logic [WSUM_W-1:0]           o_window_sum;
    logic [AREA_W-1:0]           o_background_x2;
    logic signed [AREA_W-1:0]    o_net_area_x2;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_INDEX_W-1:0]      i_cfg_index = REG_NUM_CHANNELS;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    histogram_scoreboard hist_sb;
    int     in_idle_pct = 26;
    int     out_idle_pct = 26;
    int     hold_off_requests = 0;
    int     hold_off_served = 0;
    int     hold_left = 0;
    longint cycle_count = 0;

    spectrum_histogram_peak_area uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_channel      (i_channel),
        .i_filters_pass (i_filters_pass),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_bin_count    (o_bin_count),
        .o_event_total  (o_event_total),
        .o_window_sum   (o_window_sum),
        .o_background_x2(o_background_x2),
        .o_net_area_x2  (o_net_area_x2),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("spectrum_histogram_peak_area: mismatch");
            $finish;
        end
    end

    // Result side: check accepted results, stall at random or for a requested hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            hist_sb.check_result({o_kind, o_bin_count, o_event_total, o_window_sum,
                                  o_background_x2, o_net_area_x2});
        if (hold_off_requests != hold_off_served) begin
            hold_off_served = hold_off_requests;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    task automatic send_request(t_action act, logic signed [CH_W-1:0] ch, logic pass);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_channel      <= ch;
        i_filters_pass <= pass;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        hist_sb.note_request(act, ch, pass);
    endtask

    task automatic write_register(t_reg_index idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        hist_sb.set_register(idx, CFG_DATA_W'(value));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold requests until every report is back, then let a trailing event finish.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (hist_sb.expected_reports.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(int nch, int lo, int hi);
        drain_results();
        write_register(REG_NUM_CHANNELS, nch);
        write_register(REG_PEAK_LOW, lo);
        write_register(REG_PEAK_HIGH, hi);
    endtask

    task automatic send_random_request();
        int      pick;
        int      win_lo;
        int      win_hi;
        t_action act;
        logic signed [CH_W-1:0] ch;
        pick = $urandom_range(99);
        if (pick < 3)       act = ACT_CLEAR;
        else if (pick < 72) act = ACT_EVENT;
        else if (pick < 84) act = ACT_FINISH;
        else                act = ACT_READ;
        win_lo = hist_sb.peak_low;
        win_hi = (hist_sb.peak_high < hist_sb.peak_low) ? win_lo : int'(hist_sb.peak_high);
        // Aim most channels at the peak window so its bins grow.
        pick = $urandom_range(99);
        if (pick < 55)
            ch = CH_W'($urandom_range((win_hi < 65535) ? win_hi + 1 : 65535,
                                      (win_lo > 0) ? win_lo - 1 : 0));
        else if (pick < 85)
            ch = CH_W'($urandom_range(0, int'(hist_sb.num_channels) + 1));
        else if (pick < 92)
            ch = -1;
        else
            ch = CH_W'($urandom_range(0, 65535));
        send_request(act, ch, $urandom_range(99) < 88);
    endtask

    task automatic run_phase(int nch, int lo, int hi, int count);
        apply_setting(nch, lo, hi);
        repeat (count) send_random_request();
    endtask

    initial begin
        int nch;
        int lo;
        hist_sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty histogram under the reset settings.
        send_request(ACT_READ, 0, 1'b1);
        send_request(ACT_FINISH, 0, 1'b1);

        apply_setting(16, 3, 6);
        send_request(ACT_EVENT, 4, 1'b1);
        send_request(ACT_EVENT, 4, 1'b1);
        send_request(ACT_EVENT, 3, 1'b1);
        send_request(ACT_EVENT, 6, 1'b1);
        send_request(ACT_EVENT, 5, 1'b0);
        send_request(ACT_EVENT, -1, 1'b1);
        send_request(ACT_EVENT, 16, 1'b1);
        send_request(ACT_EVENT, 65535, 1'b1);
        send_request(ACT_EVENT, 15, 1'b1);
        send_request(ACT_READ, 4, 1'b0);
        send_request(ACT_READ, -1, 1'b1);
        send_request(ACT_READ, 65535, 1'b1);
        send_request(ACT_READ, 16, 1'b1);
        send_request(ACT_FINISH, 0, 1'b1);

        // Reversed window collapses to its low edge.
        apply_setting(16, 6, 3);
        send_request(ACT_FINISH, 0, 1'b1);
        send_request(ACT_CLEAR, 0, 1'b1);
        send_request(ACT_READ, 4, 1'b1);

        // Window running far past the bins in use.
        apply_setting(32, 0, 65535);
        send_request(ACT_EVENT, 0, 1'b1);
        send_request(ACT_EVENT, 31, 1'b1);
        send_request(ACT_FINISH, 0, 1'b1);

        // No bins in use at all.
        apply_setting(0, 0, 4);
        send_request(ACT_EVENT, 2, 1'b1);
        send_request(ACT_READ, 2, 1'b1);
        send_request(ACT_FINISH, 0, 1'b1);

        run_phase(16'hFFFF, 0, 4095, 60);
        run_phase(1, 0, 0, 60);

        // Stall the result side long enough to back up the request side.
        apply_setting(64, 20, 40);
        hold_off_requests++;
        repeat (6) send_request(ACT_READ, CH_W'($urandom_range(15, 45)), 1'b1);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        repeat (70) send_random_request();
        in_idle_pct  = 26;
        out_idle_pct = 26;

        run_phase(0, 0, 5, 55);
        run_phase(200, 150, 100, 60);
        run_phase(4096, 65535, 65535, 55);
        run_phase(8, 7, 7, 55);
        repeat (2) begin
            nch = $urandom_range(1, 48);
            lo  = $urandom_range(0, nch + 4);
            run_phase(nch, lo, lo + $urandom_range(0, 10) - 2, 60);
        end

        drain_results();
        if (hist_sb.expected_reports.size() > 0)
            hist_sb.flag_mismatch($sformatf("%0d expected results never arrived",
                                            hist_sb.expected_reports.size()));
        if (hist_sb.mismatches == 0)
            $display("spectrum_histogram_peak_area: match");
        else
            $display("spectrum_histogram_peak_area: mismatch");
        $finish;
    end
endmodule

// File: sim.f
sv/shpa_pkg.sv
sv/shpa_ctrl.sv
sv/shpa_dp.sv
sv/spectrum_histogram_peak_area.sv
tb/tb_top.sv
